FILE: rtl/ctgi_pkg.sv
// ----------------------------------------------------------------------------
// ctgi_pkg
// shared constants for the cached trilinear grid interpolator
// ----------------------------------------------------------------------------
package ctgi_pkg;

    localparam int FULL_DEPTH_DEF = 65536;
    localparam int SLOT_DEPTH_DEF = 32768;
    localparam int Z_PITCH_DEF    = 1;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_WR_IDX = 2'd1;
    localparam logic [1:0] OP_WR_VAL = 2'd2;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] REG_Z_ORIGIN = 3'd2;
    localparam logic [2:0] REG_X_INV    = 3'd3;
    localparam logic [2:0] REG_Y_INV    = 3'd4;
    localparam logic [2:0] REG_Z_INV    = 3'd5;
    localparam logic [2:0] REG_X_PITCH  = 3'd6;
    localparam logic [2:0] REG_Y_PITCH  = 3'd7;

    localparam int IN_W  = 152;
    localparam int OUT_W = 40;

endpackage

FILE: rtl/cached_trilinear_grid_interp.sv
// ----------------------------------------------------------------------------
// cached_trilinear_grid_interp
// trilinear interpolation over a sparse grid with a one-cell corner cache
// ----------------------------------------------------------------------------
// a table write completes at its input transfer and returns nothing; a query
// result is produced directly when an axis is out of range, from the cached
// corners on a cache hit and from the table reads on a miss (ending early when a
// corner falls outside the tables)
// one item at a time; input is ready again the cycle after the result transfer
// reset clears the cache, state and configuration registers; table memories hold no reset value
module cached_trilinear_grid_interp
    import ctgi_pkg::*;
#(
    parameter int FULL_DEPTH = FULL_DEPTH_DEF,
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF,
    parameter int Z_PITCH    = Z_PITCH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66],
    // table_addr[113:98], table_data[145:114]
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result_value[31:0], out_of_range[32]
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int FA = (FULL_DEPTH > 1) ? $clog2(FULL_DEPTH) : 1;
    localparam int SA = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_SPLIT = 10'b0000000100,
        ST_ADDR  = 10'b0000001000,
        ST_IRD   = 10'b0000010000,
        ST_VRD   = 10'b0000100000,
        ST_LMUL  = 10'b0001000000,
        ST_LADD  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_BASE  = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic signed [31:0] x_org_reg, y_org_reg, z_org_reg;
    logic [31:0] x_inv_reg, y_inv_reg, z_inv_reg;
    logic [15:0] x_pitch_reg, y_pitch_reg;

    logic [14:0] idx_mem [FULL_DEPTH];
    logic [31:0] val_mem [SLOT_DEPTH];
    logic [14:0] idx_rd;
    logic [31:0] val_rd;

    logic signed [32:0] d_reg [3];
    logic [1:0]  ax_reg;
    logic [63:0] m_reg;
    logic [15:0] cell_reg [3];
    logic [15:0] frac_reg [3];
    logic        oor_reg;

    logic [15:0] cc_reg [3];
    logic        cv_reg;
    logic [31:0] cc_corner_reg [8];
    logic [31:0] c_reg [8];
    logic [14:0] slot_reg [8];

    logic [33:0] base_reg;
    logic [3:0]  k_reg;
    logic        rd_pend_reg;
    logic [2:0]  l_reg;
    logic signed [48:0] p_reg;
    logic [31:0] res_reg;
    logic        res_oor_reg;
    logic        out_valid_reg;

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_oor_reg, res_reg};

    // corner address for counter k
    logic [33:0] corner_addr;
    always_comb
    begin
        corner_addr = base_reg
            + (k_reg[2] ? 34'(x_pitch_reg) : 34'd0)
            + (k_reg[1] ? 34'(y_pitch_reg) : 34'd0)
            + (k_reg[0] ? 34'(Z_PITCH) : 34'd0);
    end

    // lerp operand selection: a, b, f
    logic [31:0] la, lb;
    logic [15:0] lf;
    always_comb
    begin
        la = c_reg[0];
        lb = c_reg[4];
        lf = frac_reg[0];
        case (l_reg)
            3'd0: begin la = c_reg[0]; lb = c_reg[4]; lf = frac_reg[0]; end
            3'd1: begin la = c_reg[1]; lb = c_reg[5]; lf = frac_reg[0]; end
            3'd2: begin la = c_reg[2]; lb = c_reg[6]; lf = frac_reg[0]; end
            3'd3: begin la = c_reg[3]; lb = c_reg[7]; lf = frac_reg[0]; end
            3'd4: begin la = c_reg[0]; lb = c_reg[2]; lf = frac_reg[1]; end
            3'd5: begin la = c_reg[1]; lb = c_reg[3]; lf = frac_reg[1]; end
            3'd6: begin la = c_reg[0]; lb = c_reg[1]; lf = frac_reg[2]; end
            default: begin la = c_reg[0]; lb = c_reg[1]; lf = frac_reg[2]; end
        endcase
    end

    logic signed [32:0] ldiff;
    logic signed [31:0] lsum;
    assign ldiff = $signed({lb[31], lb}) - $signed({la[31], la});
    assign lsum  = 32'($signed(la) + $signed(p_reg >>> 16));

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    assign mul_a = d_reg[ax_reg];
    assign mul_b = (ax_reg == 2'd0) ? x_inv_reg : (ax_reg == 2'd1) ? y_inv_reg : z_inv_reg;

    logic hit;
    assign hit = cv_reg && cell_reg[0] == cc_reg[0] && cell_reg[1] == cc_reg[1]
                 && cell_reg[2] == cc_reg[2];

    // memories
    logic        idx_we, val_we;
    logic [FA-1:0] idx_wa, idx_ra;
    logic [SA-1:0] val_wa, val_ra;
    logic [31:0] wr_data;
    assign wr_data = s_axis_tdata[145:114];
    assign idx_wa  = FA'(s_axis_tdata[113:98]);
    assign val_wa  = SA'(s_axis_tdata[113:98]);
    assign idx_we  = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_WR_IDX
                     && 32'(s_axis_tdata[113:98]) < 32'(FULL_DEPTH);
    assign val_we  = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_WR_VAL
                     && 32'(s_axis_tdata[113:98]) < 32'(SLOT_DEPTH);
    assign idx_ra  = FA'(corner_addr);
    assign val_ra  = SA'(slot_reg[k_reg[2:0]]);

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_mem[idx_wa] <= wr_data[14:0];
        end
        idx_rd <= idx_mem[idx_ra];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= wr_data;
        end
        val_rd <= val_mem[val_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_org_reg     <= '0;
            y_org_reg     <= '0;
            z_org_reg     <= '0;
            x_inv_reg     <= 32'd65536;
            y_inv_reg     <= 32'd65536;
            z_inv_reg     <= 32'd65536;
            x_pitch_reg   <= 16'd256;
            y_pitch_reg   <= 16'd16;
            cv_reg        <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cc_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                cc_corner_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            ax_reg        <= '0;
            k_reg         <= '0;
            l_reg         <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_X_ORIGIN: x_org_reg   <= cfg_data;
                    REG_Y_ORIGIN: y_org_reg   <= cfg_data;
                    REG_Z_ORIGIN: z_org_reg   <= cfg_data;
                    REG_X_INV:    x_inv_reg   <= cfg_data;
                    REG_Y_INV:    y_inv_reg   <= cfg_data;
                    REG_Z_INV:    z_inv_reg   <= cfg_data;
                    REG_X_PITCH:  x_pitch_reg <= cfg_data[15:0];
                    REG_Y_PITCH:  y_pitch_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        d_reg[0] <= $signed({s_axis_tdata[33], s_axis_tdata[33:2]})
                                    - $signed({x_org_reg[31], x_org_reg});
                        d_reg[1] <= $signed({s_axis_tdata[65], s_axis_tdata[65:34]})
                                    - $signed({y_org_reg[31], y_org_reg});
                        d_reg[2] <= $signed({s_axis_tdata[97], s_axis_tdata[97:66]})
                                    - $signed({z_org_reg[31], z_org_reg});
                        oor_reg  <= 1'b0;
                        ax_reg   <= '0;
                        if (s_axis_tdata[1:0] == OP_WR_IDX || s_axis_tdata[1:0] == OP_WR_VAL)
                        begin
                            cv_reg <= 1'b0;
                        end
                        if (s_axis_tdata[1:0] == OP_QUERY)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (d_reg[ax_reg][32])
                    begin
                        oor_reg <= 1'b1;
                    end
                    m_reg     <= 64'(mul_a[31:0]) * 64'(mul_b);
                    state_reg <= ST_SPLIT;
                end
                ST_SPLIT:
                begin
                    if (m_reg[63:48] != 16'd0)
                    begin
                        oor_reg <= 1'b1;
                    end
                    cell_reg[ax_reg] <= m_reg[47:32];
                    frac_reg[ax_reg] <= m_reg[31:16];
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_ADDR;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_ADDR:
                begin
                    k_reg       <= '0;
                    rd_pend_reg <= 1'b0;
                    if (oor_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (hit)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            c_reg[i] <= cc_corner_reg[i];
                        end
                        l_reg     <= '0;
                        state_reg <= ST_LMUL;
                    end
                    else
                    begin
                        base_reg  <= 34'(32'(cell_reg[0]) * 32'(x_pitch_reg));
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE:
                begin
                    base_reg  <= base_reg + 34'(32'(cell_reg[1]) * 32'(y_pitch_reg))
                                 + 34'(cell_reg[2]) * 34'(Z_PITCH);
                    state_reg <= ST_IRD;
                end
                ST_IRD:
                begin
                    if (!rd_pend_reg)
                    begin
                        if (corner_addr >= 34'(FULL_DEPTH))
                        begin
                            oor_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        if (32'(idx_rd) >= 32'(SLOT_DEPTH))
                        begin
                            oor_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            slot_reg[k_reg[2:0]] <= idx_rd;
                            if (k_reg == 4'd7)
                            begin
                                k_reg     <= '0;
                                state_reg <= ST_VRD;
                            end
                            else
                            begin
                                k_reg <= k_reg + 4'd1;
                            end
                        end
                    end
                end
                ST_VRD:
                begin
                    if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        c_reg[k_reg[2:0]] <= val_rd;
                        if (k_reg == 4'd7)
                        begin
                            state_reg <= ST_LMUL;
                            l_reg     <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 4'd1;
                        end
                    end
                end
                ST_LMUL:
                begin
                    if (l_reg == 3'd0)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            cc_corner_reg[i] <= c_reg[i];
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            cc_reg[i] <= cell_reg[i];
                        end
                        cv_reg <= 1'b1;
                    end
                    p_reg     <= 49'(ldiff * $signed({1'b0, lf}));
                    state_reg <= ST_LADD;
                end
                ST_LADD:
                begin
                    case (l_reg)
                        3'd0: c_reg[0] <= lsum;
                        3'd1: c_reg[1] <= lsum;
                        3'd2: c_reg[2] <= lsum;
                        3'd3: c_reg[3] <= lsum;
                        3'd4: c_reg[0] <= lsum;
                        3'd5: c_reg[1] <= lsum;
                        default: c_reg[0] <= lsum;
                    endcase
                    if (l_reg == 3'd6)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        l_reg     <= l_reg + 3'd1;
                        state_reg <= ST_LMUL;
                    end
                end
                ST_OUT:
                begin
                    res_reg       <= oor_reg ? 32'd0 : c_reg[0];
                    res_oor_reg   <= oor_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/ctgi_checker.sv
// ----------------------------------------------------------------------------
// ctgi_checker
// port-level checks for the cached trilinear grid interpolator
// ----------------------------------------------------------------------------
module ctgi_checker
    import ctgi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an out of range result carries a zero value
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("out of range result not zero");

    // no new item while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");

    // a table write produces no result next cycle
    a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_QUERY
        |=> !m_axis_tvalid)
        else $error("result after table write");

endmodule

bind cached_trilinear_grid_interp ctgi_checker u_ctgi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
